// File: rtl/gwm_pkg.sv
// shared constants, types and helpers of the glob wildcard matcher
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

   // pattern row size and derived widths
   localparam int PATTERN_ELEMENTS = 64;
   localparam int POS_W = PATTERN_ELEMENTS + 1;
   localparam int CNT_W = $clog2(PATTERN_ELEMENTS + 1);

   // request operations
   typedef logic [1:0] op_type;
   localparam op_type OP_APPEND = 2'd0;
   localparam op_type OP_CLEAR  = 2'd1;
   localparam op_type OP_DATA   = 2'd2;
   localparam op_type OP_END    = 2'd3;

   // element kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LITERAL = 2'd0;
   localparam kind_type KIND_ANY_ONE = 2'd1;
   localparam kind_type KIND_ANY_RUN = 2'd2;

   // special pattern characters
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CASE_OFFSET    = 8'h20;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic       load;
      logic       data;
      logic       restart;
      kind_type   kind;
      logic [7:0] symbol;
   } cell_ctrl_type;

   // map upper-case ascii letters onto lower case
   function automatic logic [7:0] fold_case(input logic [7:0] sym);
      logic [7:0] res;
      res = sym;
      if (sym >= CHAR_UPPER_A && sym <= CHAR_UPPER_Z) begin
         res = sym + CASE_OFFSET;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/gwm_req_if.sv
// request channel: operation and symbol beats into the matcher
`timescale 1ns / 1ps
`default_nettype none

interface gwm_req_if;
   logic              valid;
   logic              ready;
   gwm_pkg::op_type   operation;
   logic [7:0]        symbol;

   modport source (output valid, output operation, output symbol, input ready);
   modport sink   (input valid, input operation, input symbol, output ready);
endinterface

`default_nettype wire

// File: rtl/gwm_rsp_if.sv
// response channel: match result beats out of the matcher
`timescale 1ns / 1ps
`default_nettype none

interface gwm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic pattern_overflow;

   modport source (output valid, output matched, output pattern_overflow, input ready);
   modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/gwm_cell.sv
// one pattern cell: stores one element and the active bit of its position
`timescale 1ns / 1ps
`default_nettype none

module gwm_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  gwm_pkg::cell_ctrl_type  ctrl,
   input  wire                     home,
   input  wire                     sel,
   input  wire                     live,
   input  wire                     closed_in,
   input  wire                     advance_in,
   output logic                    active_out,
   output logic                    run_out,
   output logic                    advance_out
);

   gwm_pkg::kind_type elem_kind_ff;
   logic [7:0]        elem_byte_ff;
   logic              active_ff;
   logic              active_in;
   logic              hit;

   // element storage, written when this cell is the next free slot
   always_ff @(posedge clock) begin
      if (ctrl.load && sel) begin
         elem_kind_ff <= ctrl.kind;
         elem_byte_ff <= ctrl.symbol;
      end
   end

   // does the current data byte move past this element
   always_comb begin
      hit = 1'b0;
      unique case (elem_kind_ff)
         gwm_pkg::KIND_ANY_ONE: hit = 1'b1;
         gwm_pkg::KIND_LITERAL: hit = (elem_byte_ff == ctrl.symbol);
         default:               hit = 1'b0;
      endcase
   end

   assign run_out     = live && (elem_kind_ff == gwm_pkg::KIND_ANY_RUN);
   assign advance_out = closed_in && live && hit;

   // next active bit: a run keeps its own position, the neighbor hands its advance
   always_comb begin
      active_in = active_ff;
      if (ctrl.restart) begin
         active_in = home;
      end else if (ctrl.data) begin
         active_in = (closed_in && run_out) || advance_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= home;
      end else begin
         active_ff <= active_in;
      end
   end

   assign active_out = active_ff;

endmodule

`default_nettype wire

// File: rtl/gwm_run_close.sv
// run closure: an active any-run element also activates the positions after it
`timescale 1ns / 1ps
`default_nettype none

module gwm_run_close (
   input  wire  [gwm_pkg::POS_W-1:0]            active_in,
   input  wire  [gwm_pkg::PATTERN_ELEMENTS-1:0] run_in,
   output logic [gwm_pkg::POS_W-1:0]            closed_out
);

   logic [gwm_pkg::PATTERN_ELEMENTS-1:0] gen;
   logic [gwm_pkg::POS_W-1:0]            sum;
   logic [gwm_pkg::POS_W-1:0]            carries;

   // carry chain: active run generates, inactive run propagates, non-run kills
   assign gen     = active_in[gwm_pkg::PATTERN_ELEMENTS-1:0] & run_in;
   assign sum     = {1'b0, gen} + {1'b0, run_in};
   assign carries = sum ^ {1'b0, gen ^ run_in};

   assign closed_out = active_in | carries;

endmodule

`default_nettype wire

// File: rtl/glob_wildcard_match.sv
// top level of the glob wildcard matcher: decode, cell row and result queue
//
// Usage:
//   req_bus carries one beat per item: operation and symbol. Append beats
//   build the pattern ('*' any run, '?' any one byte, backslash escapes the
//   next byte), clear empties it, data beats stream the string through the
//   row of cells, and an end-of-data beat yields one rsp_bus beat holding
//   matched and pattern_overflow, then restarts matching for the next string.
//   Literals compare case-blind for ascii letters.
//   Throughput: one request beat per cycle while req_bus.ready is high; each
//   beat updates the row of active positions in the cycle it is accepted,
//   through one carry chain across the row that closes any-run elements.
//   Response: each result is registered in the output or the skid register.
//   Reset (synchronous): pattern empty, no overflow, position zero active,
//   response queue empty.
//   Stall: a two-entry response queue (output register plus skid register)
//   keeps taking requests while one response waits; req_bus.ready drops only
//   when both entries are held.
`timescale 1ns / 1ps
`default_nettype none

module glob_wildcard_match (
   input  wire         clock,
   input  wire         reset,
   gwm_req_if.sink     req_bus,
   gwm_rsp_if.source   rsp_bus
);

   localparam int N = gwm_pkg::PATTERN_ELEMENTS;

   logic                      accept;
   logic                      is_append;
   logic                      is_clear;
   logic                      is_data;
   logic                      is_end;
   logic                      make;
   gwm_pkg::kind_type         make_kind;
   logic                      full;
   logic                      esc_ff;
   logic                      esc_in;
   logic                      too_long_ff;
   logic                      too_long_in;
   logic [gwm_pkg::CNT_W-1:0] count_ff;
   logic [gwm_pkg::CNT_W-1:0] count_in;
   logic                      top_ff;
   logic                      top_in;
   gwm_pkg::cell_ctrl_type    ctrl;
   logic [N-1:0]              active_vec;
   logic [N-1:0]              run_vec;
   logic [N:0]                adv_chain;
   logic [gwm_pkg::POS_W-1:0] closed;
   logic                      hit;
   logic                      out_valid_ff;
   logic                      out_matched_ff;
   logic                      out_ovf_ff;
   logic                      skid_valid_ff;
   logic                      skid_matched_ff;
   logic                      skid_ovf_ff;
   logic                      push;
   logic                      pop;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   // operation decode
   always_comb begin
      is_append = 1'b0;
      is_clear  = 1'b0;
      is_data   = 1'b0;
      is_end    = 1'b0;
      unique case (req_bus.operation)
         gwm_pkg::OP_APPEND: is_append = accept;
         gwm_pkg::OP_CLEAR:  is_clear  = accept;
         gwm_pkg::OP_DATA:   is_data   = accept;
         gwm_pkg::OP_END:    is_end    = accept;
         default:            is_data   = 1'b0;
      endcase
   end

   // pattern byte parsing with backslash escape
   always_comb begin
      make      = 1'b0;
      make_kind = gwm_pkg::KIND_LITERAL;
      esc_in    = esc_ff;
      if (is_clear) begin
         esc_in = 1'b0;
      end else if (is_append) begin
         priority if (esc_ff) begin
            esc_in = 1'b0;
            make   = 1'b1;
         end else if (req_bus.symbol == gwm_pkg::CHAR_BACKSLASH) begin
            esc_in = 1'b1;
         end else if (req_bus.symbol == gwm_pkg::CHAR_STAR) begin
            make      = 1'b1;
            make_kind = gwm_pkg::KIND_ANY_RUN;
         end else if (req_bus.symbol == gwm_pkg::CHAR_QUESTION) begin
            make      = 1'b1;
            make_kind = gwm_pkg::KIND_ANY_ONE;
         end else begin
            make = 1'b1;
         end
      end
   end

   // element count and overflow flag
   assign full = (count_ff == gwm_pkg::CNT_W'(N));

   always_comb begin
      count_in    = count_ff;
      too_long_in = too_long_ff;
      if (is_clear) begin
         count_in    = '0;
         too_long_in = 1'b0;
      end else if (make) begin
         if (full) begin
            too_long_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff      <= 1'b0;
         too_long_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         esc_ff      <= esc_in;
         too_long_ff <= too_long_in;
         count_ff    <= count_in;
      end
   end

   // broadcast to the cells
   assign ctrl.load    = make && !full;
   assign ctrl.data    = is_data;
   assign ctrl.restart = is_clear || is_end;
   assign ctrl.kind    = make_kind;
   assign ctrl.symbol  = gwm_pkg::fold_case(req_bus.symbol);

   // row of cells, each passing its advance to the next position
   assign adv_chain[0] = 1'b0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      gwm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .home        (i == 0),
         .sel         (count_ff == gwm_pkg::CNT_W'(i)),
         .live        (gwm_pkg::CNT_W'(i) < count_ff),
         .closed_in   (closed[i]),
         .advance_in  (adv_chain[i]),
         .active_out  (active_vec[i]),
         .run_out     (run_vec[i]),
         .advance_out (adv_chain[i+1])
      );
   end

   // position past a full row
   always_comb begin
      top_in = top_ff;
      if (ctrl.restart) begin
         top_in = 1'b0;
      end else if (is_data) begin
         top_in = adv_chain[N];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= 1'b0;
      end else begin
         top_ff <= top_in;
      end
   end

   gwm_run_close u_run_close (
      .active_in  ({top_ff, active_vec}),
      .run_in     (run_vec),
      .closed_out (closed)
   );

   assign hit = closed[count_ff] && !too_long_ff;

   // two-entry response queue
   assign push = is_end;
   assign pop  = out_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (pop) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (!out_valid_ff || pop) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_matched_ff <= skid_matched_ff;
            out_ovf_ff     <= skid_ovf_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_matched_ff <= hit;
            out_ovf_ff     <= too_long_ff;
         end else begin
            skid_matched_ff <= hit;
            skid_ovf_ff     <= too_long_ff;
         end
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.matched          = out_matched_ff;
   assign rsp_bus.pattern_overflow = out_ovf_ff;

   // checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= gwm_pkg::CNT_W'(N))
      else $error("element count beyond row size");

   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      is_clear |=> (count_ff == '0) && !too_long_ff && !esc_ff && active_vec[0] && !top_ff)
      else $error("clear did not restart the pattern");

   a_overflow_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.pattern_overflow) |-> !rsp_bus.matched)
      else $error("match reported with overflowed pattern");

endmodule

`default_nettype wire

// File: tb/sv/tb_glob_wildcard_match.sv
// testbench for the glob wildcard matcher: directed script, random glob sessions, checker
`timescale 1ns / 1ps

module tb_glob_wildcard_match;
   import gwm_pkg::*;

   localparam int RANDOM_BEATS    = 850;
   localparam int HOLD_OFF_CYCLES = 300;

   // one match report as it leaves the block
   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_t;

   localparam verdict_t HIT  = '{matched: 1'b1, overflow: 1'b0};
   localparam verdict_t MISS = '{matched: 1'b0, overflow: 1'b0};

   // receiver behaviors
   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

   // directed script row; the verdict column counts only when fixed is set
   typedef struct packed {
      op_type     op;
      logic [7:0] sym;
      logic       fixed;
      verdict_t   verdict;
   } script_row_t;

   localparam int SCRIPT_ROWS = 26;
   localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
      // empty pattern against the empty string, then against a zero byte
      '{OP_END,    8'h00,          1'b1, HIT},
      '{OP_DATA,   8'h00,          1'b0, MISS},
      '{OP_END,    8'hFF,          1'b1, MISS},
      // literal, any-one, any-run, escaped star, trailing backslash
      '{OP_APPEND, "A",            1'b0, MISS},
      '{OP_APPEND, CHAR_QUESTION,  1'b0, MISS},
      '{OP_APPEND, CHAR_STAR,      1'b0, MISS},
      '{OP_APPEND, CHAR_BACKSLASH, 1'b0, MISS},
      '{OP_APPEND, CHAR_STAR,      1'b0, MISS},
      '{OP_APPEND, CHAR_BACKSLASH, 1'b0, MISS},
      '{OP_DATA,   "a",            1'b0, MISS},
      '{OP_DATA,   8'hFF,          1'b0, MISS},
      '{OP_DATA,   "x",            1'b0, MISS},
      '{OP_DATA,   CHAR_STAR,      1'b0, MISS},
      '{OP_END,    8'h00,          1'b0, MISS},
      // clear back to the empty pattern
      '{OP_CLEAR,  8'hFF,          1'b0, MISS},
      '{OP_DATA,   "Q",            1'b0, MISS},
      '{OP_END,    8'h00,          1'b1, MISS},
      // pattern grown while a string is streaming
      '{OP_APPEND, "b",            1'b0, MISS},
      '{OP_DATA,   "B",            1'b0, MISS},
      '{OP_APPEND, CHAR_STAR,      1'b0, MISS},
      '{OP_END,    8'h00,          1'b0, MISS},
      // escaped backslash stored as a literal
      '{OP_APPEND, CHAR_BACKSLASH, 1'b0, MISS},
      '{OP_APPEND, CHAR_BACKSLASH, 1'b0, MISS},
      '{OP_DATA,   "b",            1'b0, MISS},
      '{OP_DATA,   CHAR_BACKSLASH, 1'b0, MISS},
      '{OP_END,    8'h00,          1'b0, MISS}
   };

   localparam logic [7:0] GLYPHS [7] = '{"a", "b", "A", "B",
                                         CHAR_STAR, CHAR_QUESTION, CHAR_BACKSLASH};

   logic clock;
   logic reset;

   gwm_req_if req_bus ();
   gwm_rsp_if rsp_bus ();

   glob_wildcard_match u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // mirror of the stored pattern and the active position set
   logic [7:0]       pat_byte [PATTERN_ELEMENTS];
   kind_type         pat_kind [PATTERN_ELEMENTS];
   int               pat_len      = 0;
   bit               esc_wait     = 1'b0;
   bit               pat_overflow = 1'b0;
   logic [POS_W-1:0] live_pos     = POS_W'(1);

   verdict_t expected_verdicts [$];

   int  beats_sent     = 0;
   int  burst_left     = 0;
   int  results_seen   = 0;
   int  hits_seen      = 0;
   int  overflows_seen = 0;
   int  mismatch_count = 0;
   int  stalled_cycles = 0;
   int  holdoffs_done  = 0;
   bit  hold_off_req   = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("timeout with %0d results still outstanding", expected_verdicts.size());
      $display("Verification failed");
      $finish;
   end

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
   endfunction

   function automatic void store_element(input kind_type k, input logic [7:0] b);
      if (pat_len >= PATTERN_ELEMENTS) begin
         pat_overflow = 1'b1;
      end else begin
         pat_kind[pat_len] = k;
         pat_byte[pat_len] = b;
         pat_len++;
      end
   endfunction

   // apply one request beat to the mirror; returns 1 when it yields a report
   function automatic bit advance_matcher(input op_type op, input logic [7:0] sym,
                                          output verdict_t verdict);
      logic [POS_W-1:0] cur;
      logic [POS_W-1:0] nxt;
      logic [7:0]       d;
      verdict = MISS;
      case (op)
         OP_APPEND: begin
            if (esc_wait) begin
               esc_wait = 1'b0;
               store_element(KIND_LITERAL, sym);
            end else if (sym == CHAR_BACKSLASH) begin
               esc_wait = 1'b1;
            end else if (sym == CHAR_STAR) begin
               store_element(KIND_ANY_RUN, 8'h00);
            end else if (sym == CHAR_QUESTION) begin
               store_element(KIND_ANY_ONE, 8'h00);
            end else begin
               store_element(KIND_LITERAL, sym);
            end
            return 1'b0;
         end
         OP_CLEAR: begin
            pat_len      = 0;
            esc_wait     = 1'b0;
            pat_overflow = 1'b0;
            live_pos     = POS_W'(1);
            return 1'b0;
         end
         default: ;
      endcase

      // active any-run positions also open the position after them
      cur = live_pos;
      for (int i = 0; i < pat_len; i++) begin
         if (cur[i] && pat_kind[i] == KIND_ANY_RUN) cur[i+1] = 1'b1;
      end

      if (op == OP_DATA) begin
         nxt = '0;
         d   = lower_ascii(sym);
         for (int i = 0; i < pat_len; i++) begin
            if (cur[i]) begin
               case (pat_kind[i])
                  KIND_ANY_RUN: nxt[i] = 1'b1;
                  KIND_ANY_ONE: nxt[i+1] = 1'b1;
                  KIND_LITERAL: if (lower_ascii(pat_byte[i]) == d) nxt[i+1] = 1'b1;
                  default: ;
               endcase
            end
         end
         live_pos = nxt;
         return 1'b0;
      end

      verdict.matched  = cur[pat_len] && !pat_overflow;
      verdict.overflow = pat_overflow;
      live_pos         = POS_W'(1);
      return 1'b1;
   endfunction

   // drive one request beat in bursts with random gaps; called just after a rising edge
   task automatic send_beat(input op_type op, input logic [7:0] sym,
                            input bit fixed, input verdict_t fixed_v);
      verdict_t v;
      int       gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.symbol    <= sym;
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      beats_sent++;
      if (advance_matcher(op, sym, v)) expected_verdicts.push_back(fixed ? fixed_v : v);
   endtask

   // one random session: a pattern built from elements, then strings aimed at it
   task automatic run_glob_session(input int idx);
      kind_type   el_kind [$];
      logic [7:0] el_byte [$];
      logic [7:0] text [$];
      int         n_el;
      int         n_str;
      int         r;
      kind_type   k;
      logic [7:0] b;

      // pure noise now and then
      if (idx > 4 && $urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(4, 12)) begin
            send_beat(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, MISS);
         end
         return;
      end

      // most sessions start fresh, the rest grow the old pattern
      if (idx < 2 || $urandom_range(0, 4) != 0) begin
         send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, MISS);
      end

      if (idx == 2)                          n_el = PATTERN_ELEMENTS + 6;
      else if (idx == 4)                     n_el = PATTERN_ELEMENTS;
      else if ($urandom_range(0, 14) == 0)   n_el = $urandom_range(60, 72);
      else                                   n_el = $urandom_range(0, 8);

      for (int e = 0; e < n_el; e++) begin
         r = $urandom_range(0, 9);
         if (r < 2) begin
            k = KIND_ANY_RUN;
            b = 8'h00;
         end else if (r == 2) begin
            k = KIND_ANY_ONE;
            b = 8'h00;
         end else begin
            k = KIND_LITERAL;
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : GLYPHS[$urandom_range(0, 6)];
         end
         el_kind.push_back(k);
         el_byte.push_back(b);
         case (k)
            KIND_ANY_RUN: send_beat(OP_APPEND, CHAR_STAR, 1'b0, MISS);
            KIND_ANY_ONE: send_beat(OP_APPEND, CHAR_QUESTION, 1'b0, MISS);
            default: begin
               // specials must be escaped, plain bytes sometimes are
               if (b == CHAR_STAR || b == CHAR_QUESTION || b == CHAR_BACKSLASH ||
                   $urandom_range(0, 7) == 0) begin
                  send_beat(OP_APPEND, CHAR_BACKSLASH, 1'b0, MISS);
               end
               send_beat(OP_APPEND, b, 1'b0, MISS);
            end
         endcase
      end
      // trailing backslash
      if ($urandom_range(0, 9) == 0) send_beat(OP_APPEND, CHAR_BACKSLASH, 1'b0, MISS);

      n_str = (n_el > 16) ? 1 : $urandom_range(1, 4);
      repeat (n_str) begin
         text.delete();
         foreach (el_kind[e]) begin
            case (el_kind[e])
               KIND_ANY_RUN: begin
                  repeat ($urandom_range(0, 3)) begin
                     text.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                               : GLYPHS[$urandom_range(0, 3)]);
                  end
               end
               KIND_ANY_ONE: text.push_back(8'($urandom_range(0, 255)));
               default: begin
                  b = el_byte[e];
                  if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) &&
                      $urandom_range(0, 1) == 1) begin
                     b = b ^ 8'h20;
                  end
                  text.push_back(b);
               end
            endcase
         end

         // damage about a third of the strings
         r = $urandom_range(0, 8);
         if (r == 0 && text.size() > 0) begin
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (r == 1 && text.size() > 0) begin
            void'(text.pop_back());
         end else if (r == 2) begin
            text.push_back(GLYPHS[$urandom_range(0, 3)]);
         end

         foreach (text[t]) begin
            if ($urandom_range(0, 39) == 0) begin
               send_beat(OP_APPEND, GLYPHS[$urandom_range(0, 6)], 1'b0, MISS);
            end
            send_beat(OP_DATA, text[t], 1'b0, MISS);
         end
         if ($urandom_range(0, 19) != 0) begin
            send_beat(OP_END, 8'($urandom_range(0, 255)), 1'b0, MISS);
         end
      end
   endtask

   // stimulus: reset, directed script, random sessions, drain
   initial begin
      int session;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_APPEND;
      req_bus.symbol    = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         send_beat(SCRIPT[i].op, SCRIPT[i].sym, SCRIPT[i].fixed, SCRIPT[i].verdict);
      end

      session = 0;
      while (beats_sent < SCRIPT_ROWS + RANDOM_BEATS) begin
         if (session == 1 || session == 12) hold_off_req = 1'b1;
         run_glob_session(session);
         session++;
      end
      req_bus.valid <= 1'b0;

      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d request beats in %0d sessions gave %0d reports: %0d hits, %0d overflowed",
               beats_sent, session, results_seen, hits_seen, overflows_seen);
      $display("receiver held off %0d times, request side stalled %0d cycles, %0d mismatches",
               holdoffs_done, stalled_cycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // receiver: changing stall behavior plus long hold-offs on request
   initial begin
      rx_mode_t mode;
      int       mode_left;
      int       tick;
      rsp_bus.ready = 1'b0;
      mode          = RX_ALWAYS;
      mode_left     = 0;
      tick          = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            holdoffs_done++;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_t'($urandom_range(0, 3));
               mode_left = $urandom_range(40, 160);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_ALWAYS: rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_bus.ready <= (tick % 4 == 0);
               default:   rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // checker: a response beat is taken at the edge after a negedge with valid and ready
   always @(negedge clock) begin
      verdict_t want;
      if (!reset) begin
         if (req_bus.valid && !req_bus.ready) stalled_cycles++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected report: matched %0b overflow %0b",
                           rsp_bus.matched, rsp_bus.pattern_overflow);
               end
            end else begin
               want = expected_verdicts.pop_front();
               results_seen++;
               hits_seen      += want.matched;
               overflows_seen += want.overflow;
               if (rsp_bus.matched !== want.matched ||
                   rsp_bus.pattern_overflow !== want.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("report %0d: matched exp %0b got %0b, overflow exp %0b got %0b",
                              results_seen, want.matched, rsp_bus.matched,
                              want.overflow, rsp_bus.pattern_overflow);
                  end
               end
            end
         end
      end
   end

endmodule
